FILE: hw/rtl/bma_pkg.sv
// Shared constants for the buddy allocator: field widths, opcodes, error codes
// and default sizes. No dependencies.
package bma_pkg;

  // default pool and handle table sizes
  localparam int ORDERS_DEF       = 10;
  localparam int HANDLE_SLOTS_DEF = 1024;

  // field widths on the channels
  localparam int SIZE_W   = 11;
  localparam int HANDLE_W = 11;
  localparam int START_W  = 10;
  localparam int UNITS_W  = 11;
  localparam int ERR_W    = 2;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NO_FIT     = 2'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_HANDLE = 2'd2;

endpackage

FILE: hw/rtl/bma_req_if.sv
// Request channel of the buddy allocator: valid/ready plus request word.
// Depends on bma_pkg.
interface bma_req_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [bma_pkg::SIZE_W-1:0]   request_size;
  logic [bma_pkg::HANDLE_W-1:0] handle_in;

  modport source (output valid, output op, output request_size, output handle_in,
                  input ready);
  modport sink (input valid, input op, input request_size, input handle_in,
                output ready);
endinterface

FILE: hw/rtl/bma_rsp_if.sv
// Response channel of the buddy allocator: valid/ready plus result word.
// Depends on bma_pkg.
interface bma_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [bma_pkg::ERR_W-1:0]    error_code;
  logic [bma_pkg::HANDLE_W-1:0] handle_out;
  logic [bma_pkg::START_W-1:0]  block_start;
  logic [bma_pkg::UNITS_W-1:0]  block_units;

  modport source (output valid, output ok, output error_code, output handle_out,
                  output block_start, output block_units, input ready);
  modport sink (input valid, input ok, input error_code, input handle_out,
                input block_start, input block_units, output ready);
endinterface

FILE: hw/rtl/buddy_memory_allocator.sv
// Buddy allocator top level: sequencer, free-node bitmap, handle table.
// Depends on bma_pkg, bma_req_if, bma_rsp_if.
//
// Usage: one request word on req (op = allocate with request_size, or free
// with handle_in), one result word on rsp for each request. req.ready is high
// only while the sequencer is idle; one request is handled at a time.
// Bitmap and handle valid bits sit in rows of up to 32 bits behind a
// registered read, so each row visit is a read state then a check state.
// An allocation scans bitmap rows from the requested order upward for a
// free node, then handle rows for an unused handle, then clears the found
// node and frees the upper half at each split level. A free reads and checks
// the handle, merges with each free buddy up to the top order, then sets the
// merged node. The longest allocation scans the whole bitmap and handle
// table.
// A new request is accepted while the previous result still waits on rsp;
// a stalled rsp only holds the next result in the sequencer until the output
// register frees up.
// After reset a clearing pass writes every bitmap and handle row, one row a
// cycle. req.ready stays low during that pass.
module buddy_memory_allocator #(
  parameter int ORDERS       = bma_pkg::ORDERS_DEF,
  parameter int HANDLE_SLOTS = bma_pkg::HANDLE_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bma_req_if.sink   req,
  bma_rsp_if.source rsp
);

  localparam int HANDLE_W = bma_pkg::HANDLE_W;
  localparam int START_W  = bma_pkg::START_W;
  localparam int UNITS_W  = bma_pkg::UNITS_W;

  localparam int KW         = $clog2(ORDERS + 1);
  localparam int SW         = ORDERS;
  localparam int NW         = ORDERS + 1;
  localparam int TREE_NODES = 2 << ORDERS;
  localparam int POOL_UNITS = 1 << ORDERS;

  // bitmap rows
  localparam int LFW   = (NW < 5) ? NW : 5;
  localparam int FW    = 1 << LFW;
  localparam int FROWS = TREE_NODES / FW;
  localparam int FRW   = (NW - LFW > 0) ? NW - LFW : 1;

  // handle valid rows
  localparam int IW      = $clog2(HANDLE_SLOTS);
  localparam int LHW     = (IW < 5) ? IW : 5;
  localparam int HW      = 1 << LHW;
  localparam int HROWS   = (HANDLE_SLOTS + HW - 1) / HW;
  localparam int HRW     = (HROWS > 1) ? $clog2(HROWS) : 1;
  localparam int HLAST_N = HANDLE_SLOTS - (HROWS - 1) * HW;
  localparam logic [HW-1:0] HLAST = HW'((64'd1 << HLAST_N) - 64'd1);

  // clearing pass
  localparam int CROWS = (FROWS > HROWS) ? FROWS : HROWS;
  localparam int CNW   = (CROWS > 1) ? $clog2(CROWS) : 1;

  typedef struct packed {
    logic [KW-1:0] order;
    logic [SW-1:0] start;
  } hent_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_FRD, S_FCHK, S_HRD, S_HCHK, S_URD, S_UWR,
    S_VRD, S_VCHK, S_MSTEP, S_MRD, S_MCHK, S_OUT
  } state_t;

  // storage
  logic [FW-1:0] fmem  [FROWS];
  logic [HW-1:0] hvmem [HROWS];
  hent_t         hdata [HANDLE_SLOTS];

  logic [FW-1:0] fq;
  logic [HW-1:0] hq;
  hent_t         hdq;

  // sequencer registers
  state_t              state;
  logic [CNW-1:0]      ccnt;
  logic                op_r;
  logic                zero_r;
  logic [KW-1:0]       t;
  logic [KW-1:0]       k;
  logic [SW-1:0]       s;
  logic [FRW-1:0]      frow;
  logic [HRW-1:0]      hrow;
  logic [IW-1:0]       slot;
  logic [NW-1:0]       unode;
  logic                uval;
  logic                res_ok;
  logic [1:0]          res_err;
  logic [HANDLE_W-1:0] res_h;
  logic [SW-1:0]       res_start;
  logic [NW-1:0]       res_units;

  // memory port controls
  logic [FRW-1:0] faddr;
  logic           fwe;
  logic [FW-1:0]  fwd;
  logic [HRW-1:0] haddr;
  logic           hwe;
  logic [HW-1:0]  hwd;
  logic           dwe;
  hent_t          dwd;

  // combinational helpers
  logic [KW-1:0]  tc;
  logic           oversize;
  logic           bad_handle;
  logic [IW-1:0]  slot_in;
  logic [31:0]    lbase;
  logic [FW-1:0]  lmask;
  logic [FRW-1:0] last_row;
  logic [FW-1:0]  fmasked;
  logic [LFW-1:0] fpos;
  logic [NW-1:0]  fnode;
  logic [SW-1:0]  s_found;
  logic [HW-1:0]  hfree;
  logic [LHW-1:0] hpos;
  logic [IW-1:0]  hslot;
  logic [LFW-1:0] upos;
  logic [LHW-1:0] spos;
  logic [KW-1:0]  kd;
  logic [KW-1:0]  nu_k;
  logic [SW-1:0]  nu_s;
  logic [NW-1:0]  nu_node;
  logic [FRW-1:0] nu_row;

  function automatic logic [FRW-1:0] first_row(input logic [KW-1:0] kk);
    logic [31:0] b;
    b = 32'd1 << (ORDERS - 32'(kk));
    return FRW'(b >> LFW);
  endfunction

  // request decode
  always_comb begin
    tc = '0;
    for (int i = 0; i < ORDERS; i++) begin
      if ((32'd1 << i) < 32'(req.request_size)) tc = KW'(i + 1);
    end
    oversize   = 32'(req.request_size) > 32'(POOL_UNITS);
    bad_handle = (req.handle_in == '0) || (32'(req.handle_in) > 32'(HANDLE_SLOTS));
    slot_in    = IW'(32'(req.handle_in) - 32'd1);
  end

  // level window in the bitmap for order k
  always_comb begin
    lbase    = 32'd1 << (ORDERS - 32'(k));
    last_row = FRW'(((lbase << 1) - 32'd1) >> LFW);
    if (lbase >= 32'(FW)) begin
      lmask = '1;
    end else begin
      lmask = FW'(((32'd1 << lbase[4:0]) - 32'd1) << lbase[4:0]);
    end
    fmasked = fq & lmask;
  end

  // lowest free node in the row
  always_comb begin
    fpos = '0;
    for (int i = FW - 1; i >= 0; i--) begin
      if (fmasked[i]) fpos = LFW'(i);
    end
    fnode   = NW'((32'(frow) << LFW) | 32'(fpos));
    s_found = SW'((32'(fnode) - lbase) << k);
  end

  // lowest unused handle in the row
  always_comb begin
    hfree = ~hq & ((hrow == HRW'(HROWS - 1)) ? HLAST : {HW{1'b1}});
    hpos  = '0;
    for (int i = HW - 1; i >= 0; i--) begin
      if (hfree[i]) hpos = LHW'(i);
    end
    hslot = IW'((32'(hrow) << LHW) | 32'(hpos));
  end

  assign upos = unode[LFW-1:0];
  assign spos = slot[LHW-1:0];
  assign kd   = k - KW'(1);

  // shared node-index unit: node = 2^(ORDERS-k) + (s >> k)
  always_comb begin
    nu_k = k;
    nu_s = s;
    case (state)
      S_UWR:   begin
        nu_k = kd;
        nu_s = s | SW'(32'd1 << kd);
      end
      S_MSTEP: begin
        if (k != KW'(ORDERS)) nu_s = s ^ SW'(32'd1 << k);
      end
      default: begin
        nu_k = k;
        nu_s = s;
      end
    endcase
    nu_node = NW'((32'd1 << (ORDERS - 32'(nu_k))) + (32'(nu_s) >> nu_k));
    nu_row  = FRW'(32'(nu_node) >> LFW);
  end

  // memory write controls
  always_comb begin
    faddr = frow;
    fwe   = 1'b0;
    fwd   = fq;
    haddr = hrow;
    hwe   = 1'b0;
    hwd   = hq;
    dwe   = 1'b0;
    dwd   = '{order: t, start: s};
    case (state)
      S_CLR: begin
        faddr = FRW'(ccnt);
        haddr = HRW'(ccnt);
        fwe   = 32'(ccnt) < 32'(FROWS);
        fwd   = (ccnt == '0) ? FW'(2) : '0;
        hwe   = 32'(ccnt) < 32'(HROWS);
        hwd   = '0;
      end
      S_UWR: begin
        fwe       = 1'b1;
        fwd[upos] = uval;
      end
      S_MCHK: begin
        fwe       = fq[upos];
        fwd[upos] = 1'b0;
      end
      S_HCHK: begin
        hwe       = |hfree;
        hwd[hpos] = 1'b1;
        dwe       = |hfree;
      end
      S_VCHK: begin
        hwe       = hq[spos];
        hwd[spos] = 1'b0;
      end
      default: begin
        fwe = 1'b0;
      end
    endcase
  end

  // memories: registered reads, one write each
  always_ff @(posedge clk) begin
    if (fwe) fmem[faddr] <= fwd;
    fq <= fmem[faddr];
  end

  always_ff @(posedge clk) begin
    if (hwe) hvmem[haddr] <= hwd;
    hq <= hvmem[haddr];
  end

  always_ff @(posedge clk) begin
    if (dwe) hdata[hslot] <= dwd;
    hdq <= hdata[slot];
  end

  assign req.ready = (state == S_IDLE);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      ccnt      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself
      if (rsp.valid && rsp.ready && state != S_OUT) rsp.valid <= 1'b0;
      case (state)
        S_CLR: begin
          ccnt <= ccnt + CNW'(1);
          if (ccnt == CNW'(CROWS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            op_r      <= req.op;
            res_ok    <= 1'b0;
            res_h     <= '0;
            res_start <= '0;
            res_units <= '0;
            if (req.op == bma_pkg::OP_ALLOC) begin
              if (oversize) begin
                res_err <= bma_pkg::ERR_NO_FIT;
                state   <= S_OUT;
              end else begin
                res_err <= bma_pkg::ERR_NONE;
                t       <= tc;
                k       <= tc;
                zero_r  <= (req.request_size == '0);
                frow    <= first_row(tc);
                state   <= S_FRD;
              end
            end else begin
              if (bad_handle) begin
                res_err <= bma_pkg::ERR_BAD_HANDLE;
                state   <= S_OUT;
              end else begin
                res_err <= bma_pkg::ERR_NONE;
                slot    <= slot_in;
                hrow    <= HRW'(32'(slot_in) >> LHW);
                state   <= S_VRD;
              end
            end
          end
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (|fmasked) begin
            if (zero_r) begin
              res_ok <= 1'b1;
              state  <= S_OUT;
            end else begin
              unode <= fnode;
              s     <= s_found;
              hrow  <= '0;
              state <= S_HRD;
            end
          end else if (frow == last_row) begin
            if (k == KW'(ORDERS)) begin
              res_err <= bma_pkg::ERR_NO_FIT;
              state   <= S_OUT;
            end else begin
              k     <= k + KW'(1);
              frow  <= first_row(k + KW'(1));
              state <= S_FRD;
            end
          end else begin
            frow  <= frow + FRW'(1);
            state <= S_FRD;
          end
        end
        S_HRD: state <= S_HCHK;
        S_HCHK: begin
          if (|hfree) begin
            slot  <= hslot;
            uval  <= 1'b0;
            frow  <= FRW'(32'(unode) >> LFW);
            state <= S_URD;
          end else if (hrow == HRW'(HROWS - 1)) begin
            res_err <= bma_pkg::ERR_NO_FIT;
            state   <= S_OUT;
          end else begin
            hrow  <= hrow + HRW'(1);
            state <= S_HRD;
          end
        end
        S_URD: state <= S_UWR;
        S_UWR: begin
          if (op_r == bma_pkg::OP_FREE) begin
            res_ok    <= 1'b1;
            res_start <= s;
            res_units <= NW'(32'd1 << k);
            state     <= S_OUT;
          end else if (k > t) begin
            // free the upper half one level down
            k     <= kd;
            unode <= nu_node;
            uval  <= 1'b1;
            frow  <= nu_row;
            state <= S_URD;
          end else begin
            res_ok    <= 1'b1;
            res_h     <= HANDLE_W'(32'(slot) + 32'd1);
            res_start <= s;
            res_units <= NW'(32'd1 << k);
            state     <= S_OUT;
          end
        end
        S_VRD: state <= S_VCHK;
        S_VCHK: begin
          if (hq[spos]) begin
            k     <= hdq.order;
            s     <= hdq.start;
            state <= S_MSTEP;
          end else begin
            res_err <= bma_pkg::ERR_BAD_HANDLE;
            state   <= S_OUT;
          end
        end
        S_MSTEP: begin
          // top order: set the node; else look at the buddy
          unode <= nu_node;
          frow  <= nu_row;
          uval  <= 1'b1;
          state <= (k == KW'(ORDERS)) ? S_URD : S_MRD;
        end
        S_MRD: state <= S_MCHK;
        S_MCHK: begin
          if (fq[upos]) begin
            s     <= s & ~SW'(32'd1 << k);
            k     <= k + KW'(1);
            state <= S_MSTEP;
          end else begin
            unode <= nu_node;
            frow  <= nu_row;
            uval  <= 1'b1;
            state <= S_URD;
          end
        end
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.ok          <= res_ok;
            rsp.error_code  <= res_err;
            rsp.handle_out  <= res_h;
            rsp.block_start <= START_W'(res_start);
            rsp.block_units <= UNITS_W'(res_units);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
